FILE: hdl/hex_grid_line_simplifier_defines.svh
// Assertion macros for the hex grid line simplifier.
// Both expect clk in scope; HGLS_ASSERT also expects rst_n.
`ifndef HEX_GRID_LINE_SIMPLIFIER_DEFINES_SVH
`define HEX_GRID_LINE_SIMPLIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
`define HGLS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hgls assertion failed");
`define HGLS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hgls assertion failed");
`else
`define HGLS_ASSERT(label, prop)
`define HGLS_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: hdl/hgls_pkg.sv
package hgls_pkg;

    localparam int COORD_W  = 24;
    localparam int SPACE_W  = 23;
    localparam int INV_W    = 24;
    localparam int DIST_W   = 48;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_W    = 28;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int MAG_W    = 27;
    localparam logic [MAG_W-1:0] CLAMP_MAX = MAG_W'(1) << 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL_WIDTH      = 3'd0,
        CFG_ROW_HEIGHT     = 3'd1,
        CFG_INV_COL_WIDTH  = 3'd2,
        CFG_INV_ROW_HEIGHT = 3'd3,
        CFG_MAX_DIST_SQ    = 3'd4,
        CFG_KEEP_ENDS      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // |d| clamped to 2^26
    function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [57:0] d);
        logic [57:0] a;
        a = d[57] ? 58'(-d) : 58'(d);
        if (a > 58'(CLAMP_MAX))
            return CLAMP_MAX;
        return a[MAG_W-1:0];
    endfunction

endpackage

FILE: hdl/hgls_ifaces.sv
interface hgls_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hgls_pkg::COORD_W-1:0] point_x;
    logic signed [hgls_pkg::COORD_W-1:0] point_y;
    logic                                 end_of_line;
    modport source (output valid, output point_x, output point_y, output end_of_line,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input end_of_line,
                  output ready);
endinterface

interface hgls_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hgls_pkg::COORD_W-1:0] out_x;
    logic signed [hgls_pkg::COORD_W-1:0] out_y;
    logic                                 kind;
    logic                                 last_of_item;
    logic                                 line_done;
    modport source (output valid, output out_x, output out_y, output kind,
                    output last_of_item, output line_done, input ready);
    modport sink (input valid, input out_x, input out_y, input kind,
                  input last_of_item, input line_done, output ready);
endinterface

interface hgls_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [hgls_pkg::CFG_IDX_W-1:0]        index;
    logic [hgls_pkg::DIST_W-1:0]           data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/hgls_mul.sv
module hgls_mul
(
    input  logic                                 clk,
    input  logic signed [hgls_pkg::MUL_W-1:0]   a,
    input  logic signed [hgls_pkg::MUL_W-1:0]   b,
    output logic signed [hgls_pkg::PROD_W-1:0]  prod
);

    logic signed [hgls_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/hgls_div.sv
module hgls_div
#(
    parameter int DW = 41,
    parameter int VW = 17
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DW-1:0]       dividend,
    input  logic [VW-1:0]       divisor,
    output hgls_pkg::div_stat_t stat,
    output logic [DW-1:0]       quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = VW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= divisor;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

FILE: hdl/hex_grid_line_simplifier.sv
// Channel  | Dir | Beat
// ---------+-----+----------------------------------------------
// cfg      | in  | index, data: register write, always ready
// points   | in  | point_x, point_y, end_of_line
// results  | out | out_x, out_y, kind, last_of_item, line_done
//
// Each point, after its accept beat, goes through cell mapping and run update:
// the first guess (C, CW, R, RS), then DX, DY, SX, SY, CMP per candidate centre,
// then CELL for the run; every product goes through the single 28x28 multiplier
// (3 for the guess, 4 per candidate). EMIT then picks results; with none left
// it returns to idle, where the next point is accepted.
// Each run mean adds two passes of the bit-serial divider, one for x and one for y,
// sequenced by DSX, DWX and DWY; copied end points go straight to PUT.
// points.ready is high only between items; results sit in an output register,
// so a stalled sink holds the sequencer only when a further beat is due.
// Reset is asynchronous, active low: registers back to their reset values,
// run state cleared.
`include "hex_grid_line_simplifier_defines.svh"

module hex_grid_line_simplifier
#(
    parameter int MAX_RUN   = 65536,
    parameter int CELL_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    hgls_cfg_if.sink      cfg,
    hgls_point_if.sink    points,
    hgls_result_if.source results
);

    localparam int COUNT_W = $clog2(MAX_RUN + 1);
    localparam int SUM_W   = 23 + COUNT_W;
    localparam int DIV_W   = SUM_W + 1;
    localparam int CW      = hgls_pkg::COORD_W;
    localparam int MW      = hgls_pkg::MUL_W;
    localparam int PW      = hgls_pkg::PROD_W;
    localparam int GW      = hgls_pkg::MAG_W;

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_C    = 16'h0002,   // (2x+cw)*icw
        ST_CW   = 16'h0004,   // column guess, c*cw
        ST_R    = 16'h0008,   // column side, row product
        ST_RS   = 16'h0010,   // row guess
        ST_DX   = 16'h0020,   // col*cw
        ST_DY   = 16'h0040,   // row*rh
        ST_SX   = 16'h0080,   // dx*dx
        ST_SY   = 16'h0100,   // dy*dy
        ST_CMP  = 16'h0200,   // nearest so far
        ST_CELL = 16'h0400,   // run update
        ST_EMIT = 16'h0800,   // pick next result
        ST_DSX  = 16'h1000,
        ST_DWX  = 16'h2000,
        ST_DWY  = 16'h4000,
        ST_PUT  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [hgls_pkg::SPACE_W-1:0] cw_reg, rh_reg;
    logic [hgls_pkg::INV_W-1:0]   icw_reg, irh_reg;
    logic [hgls_pkg::DIST_W-1:0]  maxd_reg;
    logic                         keep_reg;

    // current item
    logic signed [CW-1:0] x_reg, y_reg;
    logic                 eol_reg;
    logic signed [CW:0]   x2, y2;

    // cell search
    logic signed [25:0]   c_reg, c_next;
    logic signed [25:0]   r_reg, r_next;
    logic                 coff_neg_reg, coff_neg_next;
    logic [1:0]           k_reg, k_next;
    logic signed [56:0]   cx2_reg, cx2_next;
    logic [GW-1:0]        dy_reg, dy_next;
    logic [52:0]          dsq_reg, dsq_next;
    logic [54:0]          best_reg, best_next;
    logic signed [26:0]   orow_reg, orow_next, ocol_reg, ocol_next;
    logic signed [26:0]   row_k, col_k;
    logic signed [56:0]   cy2;
    logic [GW-1:0]        dx;
    logic [54:0]          cand_dist;

    // run state
    logic [CELL_BITS-1:0]    run_row_reg, run_row_next, run_col_reg, run_col_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0]      run_count_reg, run_count_next;
    logic [1:0]              pidx_reg, pidx_next;
    logic signed [CW-1:0]    first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [CELL_BITS-1:0]    cell_row, cell_col;
    logic                    same;

    // pending results of this item, in emit order
    logic pend_first_reg, pend_first_next, pend_old_reg, pend_old_next;
    logic pend_eol_reg, pend_eol_next, pend_last_reg, pend_last_next;
    logic signed [SUM_W-1:0] msx_reg, msx_next, msy_reg, msy_next;
    logic [COUNT_W-1:0]      mn_reg, mn_next;

    logic signed [CW-1:0] qx_reg, qx_next;
    logic signed [CW-1:0] put_x_reg, put_x_next, put_y_reg, put_y_next;
    logic                 put_kind_reg, put_kind_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic signed [CW-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                 out_kind_reg, out_kind_next, out_last_reg, out_last_next;
    logic                 out_done_reg, out_done_next;
    logic                 out_free;

    // shared units
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend, div_q;
    logic signed [DIV_W-1:0] div_sum;
    logic [DIV_W-1:0]     div_mag;
    logic                 div_neg;
    logic signed [CW-1:0] mean_val;
    hgls_pkg::div_stat_t  div_stat;

    hgls_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    hgls_div #(.DW(DIV_W), .VW(COUNT_W)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (mn_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign cfg.ready    = 1'b1;
    assign points.ready = (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || results.ready;

    assign x2 = {x_reg, 1'b0};
    assign y2 = {y_reg, 1'b0};

    // candidates: (r,c), (r,c+cOff), (r+rOff,c+cOff); rOff is -1 on even columns
    always_comb
    begin
        row_k = 27'(r_reg);
        col_k = 27'(c_reg);
        if (k_reg != 2'd0)
            col_k = 27'(c_reg) + (coff_neg_reg ? -27'sd1 : 27'sd1);
        if (k_reg == 2'd2)
            row_k = 27'(r_reg) + (c_reg[0] ? 27'sd1 : -27'sd1);
    end

    assign cy2  = $signed({prod[55:0], 1'b0}) + $signed({34'b0, col_k[0] ? rh_reg : 23'd0});
    assign dx   = hgls_pkg::clamp_mag(58'(x2) - 58'(cx2_reg));
    assign cand_dist = 55'(dsq_reg) + 55'(prod[52:0]);

    assign cell_row = CELL_BITS'(orow_reg);
    assign cell_col = CELL_BITS'(ocol_reg);
    assign same     = (cell_row == run_row_reg) && (cell_col == run_col_reg);

    // run mean: (|s| + n/2) / n, sign put back
    assign div_sum      = (state_reg == ST_DSX) ? DIV_W'(msx_reg) : DIV_W'(msy_reg);
    assign div_mag      = div_sum[DIV_W-1] ? DIV_W'(-div_sum) : DIV_W'(div_sum);
    assign div_dividend = div_mag + DIV_W'(mn_reg >> 1);
    assign div_start    = (state_reg == ST_DSX) ||
                          (state_reg == ST_DWX && div_stat.done);
    assign div_neg      = (state_reg == ST_DWX) ? msx_reg[SUM_W-1] : msy_reg[SUM_W-1];
    assign mean_val     = div_neg ? CW'(-div_q[CW-1:0]) : CW'(div_q[CW-1:0]);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_C:
            begin
                mul_a = MW'(x2) + $signed({5'b0, cw_reg});
                mul_b = $signed({4'b0, icw_reg});
            end
            ST_CW:
            begin
                mul_a = MW'($signed(prod[50:25]));
                mul_b = $signed({5'b0, cw_reg});
            end
            ST_R:
            begin
                mul_a = c_reg[0] ? MW'(y_reg) : MW'(y2) + $signed({5'b0, rh_reg});
                mul_b = $signed({4'b0, irh_reg});
            end
            ST_DX:
            begin
                mul_a = MW'(col_k);
                mul_b = $signed({5'b0, cw_reg});
            end
            ST_DY:
            begin
                mul_a = MW'(row_k);
                mul_b = $signed({5'b0, rh_reg});
            end
            ST_SX:
            begin
                mul_a = $signed({1'b0, dx});
                mul_b = $signed({1'b0, dx});
            end
            ST_SY:
            begin
                mul_a = $signed({1'b0, dy_reg});
                mul_b = $signed({1'b0, dy_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        coff_neg_next   = coff_neg_reg;
        k_next          = k_reg;
        cx2_next        = cx2_reg;
        dy_next         = dy_reg;
        dsq_next        = dsq_reg;
        best_next       = best_reg;
        orow_next       = orow_reg;
        ocol_next       = ocol_reg;
        run_row_next    = run_row_reg;
        run_col_next    = run_col_reg;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        run_count_next  = run_count_reg;
        pidx_next       = pidx_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        pend_first_next = pend_first_reg;
        pend_old_next   = pend_old_reg;
        pend_eol_next   = pend_eol_reg;
        pend_last_next  = pend_last_reg;
        msx_next        = msx_reg;
        msy_next        = msy_reg;
        mn_next         = mn_reg;
        qx_next         = qx_reg;
        put_x_next      = put_x_reg;
        put_y_next      = put_y_reg;
        put_kind_next   = put_kind_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (points.valid)
                    state_next = ST_C;
            end
            ST_C:
                state_next = ST_CW;
            ST_CW:
            begin
                c_next     = prod[50:25];
                state_next = ST_R;
            end
            ST_R:
            begin
                // cOff = -1 when 2x < 2*C*col_width
                coff_neg_next = 57'(x2) < $signed({prod[55:0], 1'b0});
                state_next    = ST_RS;
            end
            ST_RS:
            begin
                r_next     = c_reg[0] ? prod[49:24] : prod[50:25];
                orow_next  = 27'(r_next);
                ocol_next  = 27'(c_reg);
                best_next  = {maxd_reg, 2'b00};
                k_next     = 2'd0;
                state_next = ST_DX;
            end
            ST_DX:
                state_next = ST_DY;
            ST_DY:
            begin
                cx2_next   = $signed({prod[55:0], 1'b0});
                state_next = ST_SX;
            end
            ST_SX:
            begin
                dy_next    = hgls_pkg::clamp_mag(58'(y2) - 58'(cy2));
                state_next = ST_SY;
            end
            ST_SY:
            begin
                dsq_next   = prod[52:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // later candidate wins a tie
                if (cand_dist <= best_reg)
                begin
                    best_next = cand_dist;
                    orow_next = row_k;
                    ocol_next = col_k;
                end
                if (k_reg == 2'd2)
                    state_next = ST_CELL;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_DX;
                end
            end
            ST_CELL:
            begin
                if (pidx_reg == 2'd0)
                begin
                    first_x_next   = x_reg;
                    first_y_next   = y_reg;
                    run_row_next   = cell_row;
                    run_col_next   = cell_col;
                    sum_x_next     = SUM_W'(x_reg);
                    sum_y_next     = SUM_W'(y_reg);
                    run_count_next = COUNT_W'(1);
                    pidx_next      = 2'd1;
                end
                else
                begin
                    pend_first_next = (pidx_reg == 2'd1) && keep_reg && same;
                    if (same && (run_count_reg < COUNT_W'(MAX_RUN)))
                    begin
                        sum_x_next     = sum_x_reg + SUM_W'(x_reg);
                        sum_y_next     = sum_y_reg + SUM_W'(y_reg);
                        run_count_next = run_count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        // close the run: mean of the old sums goes out
                        pend_old_next  = 1'b1;
                        msx_next       = sum_x_reg;
                        msy_next       = sum_y_reg;
                        mn_next        = run_count_reg;
                        run_row_next   = cell_row;
                        run_col_next   = cell_col;
                        sum_x_next     = SUM_W'(x_reg);
                        sum_y_next     = SUM_W'(y_reg);
                        run_count_next = COUNT_W'(1);
                    end
                    pidx_next = 2'd2;
                end
                if (eol_reg)
                begin
                    pend_eol_next  = 1'b1;
                    pend_last_next = keep_reg && (run_count_next > COUNT_W'(1));
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                priority if (pend_first_reg)
                begin
                    pend_first_next = 1'b0;
                    put_x_next      = first_x_reg;
                    put_y_next      = first_y_reg;
                    put_kind_next   = 1'b1;
                    state_next      = ST_PUT;
                end
                else if (pend_old_reg)
                begin
                    pend_old_next = 1'b0;
                    state_next    = ST_DSX;
                end
                else if (pend_eol_reg)
                begin
                    // take the final run, then clear the line state
                    pend_eol_next  = 1'b0;
                    msx_next       = sum_x_reg;
                    msy_next       = sum_y_reg;
                    mn_next        = run_count_reg;
                    run_row_next   = '0;
                    run_col_next   = '0;
                    sum_x_next     = '0;
                    sum_y_next     = '0;
                    run_count_next = '0;
                    pidx_next      = 2'd0;
                    first_x_next   = '0;
                    first_y_next   = '0;
                    state_next     = ST_DSX;
                end
                else if (pend_last_reg)
                begin
                    pend_last_next = 1'b0;
                    put_x_next     = x_reg;
                    put_y_next     = y_reg;
                    put_kind_next  = 1'b1;
                    state_next     = ST_PUT;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DSX:
                state_next = ST_DWX;
            ST_DWX:
            begin
                if (div_stat.done)
                begin
                    qx_next    = mean_val;
                    state_next = ST_DWY;
                end
            end
            ST_DWY:
            begin
                if (div_stat.done)
                begin
                    put_x_next    = qx_reg;
                    put_y_next    = mean_val;
                    put_kind_next = 1'b0;
                    state_next    = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = put_x_reg;
                    out_y_next     = put_y_reg;
                    out_kind_next  = put_kind_reg;
                    out_last_next  = !(pend_first_reg || pend_old_reg ||
                                       pend_eol_reg || pend_last_reg);
                    out_done_next  = eol_reg && out_last_next;
                    state_next     = ST_EMIT;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cw_reg         <= 23'd384;
            rh_reg         <= 23'd443;
            icw_reg        <= 24'd43691;
            irh_reg        <= 24'd37837;
            maxd_reg       <= 48'd131072;
            keep_reg       <= 1'b1;
            run_row_reg    <= '0;
            run_col_reg    <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            run_count_reg  <= '0;
            pidx_reg       <= 2'd0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            pend_first_reg <= 1'b0;
            pend_old_reg   <= 1'b0;
            pend_eol_reg   <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_row_reg    <= run_row_next;
            run_col_reg    <= run_col_next;
            sum_x_reg      <= sum_x_next;
            sum_y_reg      <= sum_y_next;
            run_count_reg  <= run_count_next;
            pidx_reg       <= pidx_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            pend_first_reg <= pend_first_next;
            pend_old_reg   <= pend_old_next;
            pend_eol_reg   <= pend_eol_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (hgls_pkg::cfg_idx_t'(cfg.index))
                    hgls_pkg::CFG_COL_WIDTH:      cw_reg   <= cfg.data[22:0];
                    hgls_pkg::CFG_ROW_HEIGHT:     rh_reg   <= cfg.data[22:0];
                    hgls_pkg::CFG_INV_COL_WIDTH:  icw_reg  <= cfg.data[23:0];
                    hgls_pkg::CFG_INV_ROW_HEIGHT: irh_reg  <= cfg.data[23:0];
                    hgls_pkg::CFG_MAX_DIST_SQ:    maxd_reg <= cfg.data;
                    hgls_pkg::CFG_KEEP_ENDS:      keep_reg <= cfg.data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (points.valid && points.ready)
        begin
            x_reg   <= points.point_x;
            y_reg   <= points.point_y;
            eol_reg <= points.end_of_line;
        end
        c_reg        <= c_next;
        r_reg        <= r_next;
        coff_neg_reg <= coff_neg_next;
        k_reg        <= k_next;
        cx2_reg      <= cx2_next;
        dy_reg       <= dy_next;
        dsq_reg      <= dsq_next;
        best_reg     <= best_next;
        orow_reg     <= orow_next;
        ocol_reg     <= ocol_next;
        msx_reg      <= msx_next;
        msy_reg      <= msy_next;
        mn_reg       <= mn_next;
        qx_reg       <= qx_next;
        put_x_reg    <= put_x_next;
        put_y_reg    <= put_y_next;
        put_kind_reg <= put_kind_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.out_x        = out_x_reg;
    assign results.out_y        = out_y_reg;
    assign results.kind         = out_kind_reg;
    assign results.last_of_item = out_last_reg;
    assign results.line_done    = out_done_reg;

    `HGLS_ASSERT(a_run_bound, run_count_reg <= COUNT_W'(MAX_RUN))
    `HGLS_ASSERT(a_one_item, (points.valid && points.ready) |=> !points.ready)
    `HGLS_ASSERT(a_div_free, div_start |-> !div_stat.busy)
    `HGLS_ASSERT(a_out_from_put, $rose(out_valid_reg) |-> $past(state_reg == ST_PUT))
    `HGLS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid_reg)

endmodule

FILE: tb/hgls_tb_ifaces.sv
`timescale 1ns / 1ps

// Testbench-side copies are not needed: the RTL interfaces are reused.
// This file holds a small shared record of one simplified point.
package hgls_tb_pkg;
    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               kind;
        logic               last_of_item;
        logic               line_done;
    } simp_point_t;
endpackage

FILE: tb/hgls_checker.sv
`timescale 1ns / 1ps

module hgls_checker
(
    input  logic          clk,
    input  logic          rst_n,
    hgls_cfg_if.sink      cfg,
    hgls_point_if.sink    points,
    hgls_result_if.sink   results,
    output int            fail_count,
    output int            pending
);

    localparam int RUN_LIMIT = 65536;
    localparam longint CMASK = 64'hFFFF;

    longint colw, rowh, icolw, irowh, dmax, keep;
    longint cur_row, cur_col, acc_x, acc_y, first_px, first_py;
    int     n_in_run, pos_in_line;
    hgls_tb_pkg::simp_point_t simp_q[$];

    function automatic longint fdiv(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    function automatic longint cmag(longint d);
        longint a;
        a = d < 0 ? -d : d;
        return a > (64'sd1 <<< 26) ? (64'sd1 <<< 26) : a;
    endfunction

    function automatic longint hex_dist(longint x2, longint y2, longint r, longint c);
        longint cx, cy, dx, dy;
        cx = 2 * c * colw;
        cy = 2 * r * rowh;
        if (c[0])
            cy += rowh;
        dx = cmag(x2 - cx);
        dy = cmag(y2 - cy);
        return dx * dx + dy * dy;
    endfunction

    function automatic longint mean_of(longint s, int n);
        longint a, q;
        if (n == 0)
            return 0;
        a = s < 0 ? -s : s;
        q = (a + n / 2) / n;
        return s < 0 ? -q : q;
    endfunction

    function automatic void push_point(longint x, longint y, logic k);
        hgls_tb_pkg::simp_point_t p;
        p.x = x[23:0];
        p.y = y[23:0];
        p.kind = k;
        p.last_of_item = 1'b0;
        p.line_done = 1'b0;
        simp_q.insert(simp_q.size(), p);
    endfunction

    task automatic predict_point(longint x, longint y, logic eol);
        longint c, r, roff, coff, best, d, br, bc;
        longint rows[3], cols[3];
        int n0;
        logic same;
        n0 = simp_q.size();
        c = fdiv((2 * x + colw) * icolw, 25);
        coff = (2 * x < 2 * c * colw) ? -1 : 1;
        if (!c[0])
        begin
            r = fdiv((2 * y + rowh) * irowh, 25);
            roff = -1;
        end
        else
        begin
            r = fdiv(y * irowh, 24);
            roff = 1;
        end
        rows = '{r, r, r + roff};
        cols = '{c, c + coff, c + coff};
        best = dmax * 4;
        br = rows[0];
        bc = cols[0];
        for (int k = 0; k < 3; k++)
        begin
            d = hex_dist(2 * x, 2 * y, rows[k], cols[k]);
            // unsigned compare: threshold may reach 4*(2^48-1), just under 2^50
            if ($unsigned(d) <= $unsigned(best))
            begin
                best = d;
                br = rows[k];
                bc = cols[k];
            end
        end
        br &= CMASK;
        bc &= CMASK;
        if (pos_in_line == 0)
        begin
            first_px = x; first_py = y;
            cur_row = br; cur_col = bc;
            acc_x = x; acc_y = y;
            n_in_run = 1;
            pos_in_line = 1;
        end
        else
        begin
            same = (br == cur_row) && (bc == cur_col);
            if (pos_in_line == 1 && keep != 0 && same)
                push_point(first_px, first_py, 1'b1);
            if (same && n_in_run < RUN_LIMIT)
            begin
                acc_x += x; acc_y += y;
                n_in_run++;
            end
            else
            begin
                push_point(mean_of(acc_x, n_in_run), mean_of(acc_y, n_in_run), 1'b0);
                cur_row = br; cur_col = bc;
                acc_x = x; acc_y = y;
                n_in_run = 1;
            end
            pos_in_line = 2;
        end
        if (eol)
        begin
            push_point(mean_of(acc_x, n_in_run), mean_of(acc_y, n_in_run), 1'b0);
            if (keep != 0 && n_in_run > 1)
                push_point(x, y, 1'b1);
            simp_q[$].line_done = 1'b1;
            cur_row = 0; cur_col = 0; acc_x = 0; acc_y = 0;
            n_in_run = 0; pos_in_line = 0; first_px = 0; first_py = 0;
        end
        if (simp_q.size() > n0)
            simp_q[$].last_of_item = 1'b1;
    endtask

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = simp_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        hgls_tb_pkg::simp_point_t e;
        if (!rst_n)
        begin
            colw = 384; rowh = 443; icolw = 43691; irowh = 37837;
            dmax = 131072; keep = 1;
            cur_row = 0; cur_col = 0; acc_x = 0; acc_y = 0;
            n_in_run = 0; pos_in_line = 0; first_px = 0; first_py = 0;
            fail_count = 0;
            simp_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (hgls_pkg::cfg_idx_t'(cfg.index))
                    hgls_pkg::CFG_COL_WIDTH:      colw  = cfg.data[22:0];
                    hgls_pkg::CFG_ROW_HEIGHT:     rowh  = cfg.data[22:0];
                    hgls_pkg::CFG_INV_COL_WIDTH:  icolw = cfg.data[23:0];
                    hgls_pkg::CFG_INV_ROW_HEIGHT: irowh = cfg.data[23:0];
                    hgls_pkg::CFG_MAX_DIST_SQ:    dmax  = cfg.data[47:0];
                    hgls_pkg::CFG_KEEP_ENDS:      keep  = cfg.data[0];
                    default: ;
                endcase
            end
            if (results.valid && results.ready)
            begin
                if (simp_q.size() == 0)
                begin
                    report("unexpected beat", results.out_x, 0);
                end
                else
                begin
                    e = simp_q.pop_front();
                    if (results.out_x !== e.x) report("out_x", results.out_x, e.x);
                    if (results.out_y !== e.y) report("out_y", results.out_y, e.y);
                    if (results.kind !== e.kind) report("kind", results.kind, e.kind);
                    if (results.last_of_item !== e.last_of_item)
                        report("last_of_item", results.last_of_item, e.last_of_item);
                    if (results.line_done !== e.line_done)
                        report("line_done", results.line_done, e.line_done);
                end
            end
            if (points.valid && points.ready)
                predict_point(longint'(points.point_x), longint'(points.point_y),
                              points.end_of_line);
        end
    end
endmodule

FILE: tb/hex_grid_line_simplifier_tb.sv
`timescale 1ns / 1ps

module hex_grid_line_simplifier_tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending;
    int   cycle_count = 0;
    // sink side: long hold-off requested by the stimulus process
    int   hold_off = 0;
    bit   stim_done = 0;

    hgls_cfg_if    cfg_ch();
    hgls_point_if  pt_ch();
    hgls_result_if res_ch();

    hex_grid_line_simplifier DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg(cfg_ch.sink), .points(pt_ch.sink), .results(res_ch.source)
    );

    hgls_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg(cfg_ch.sink), .points(pt_ch.sink), .results(res_ch.sink),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Worst case per point: mapping and sequencing, plus up to 3 results, each with
    // a divide, a put and a sink stall, plus a sender gap; all points plus drains
    // and the hold-off stay under the limit below.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result sink: random stall per beat, plus a long hold-off on request.
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (hold_off > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            if (gap > 0 && !stim_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready))
                @(posedge clk);
        end
    end

    task automatic write_reg(hgls_pkg::cfg_idx_t idx, longint value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value[47:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One point beat; sender gap drawn per beat, sometimes none at all.
    // valid stays high after the beat until the next gap or drain lowers it.
    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, logic eol,
                              bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.point_x <= x;
        pt_ch.point_y <= y;
        pt_ch.end_of_line <= eol;
        @(posedge clk);
        while (!pt_ch.ready)
            @(posedge clk);
    endtask

    // Wait until all simplified points are back, then let the divider drain.
    task automatic drain();
        pt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // A polyline that wanders near a start point, so runs repeat cells.
    task automatic send_line(int npts, int step, bit quiet);
        logic signed [23:0] x, y;
        x = 24'($urandom);
        y = 24'($urandom);
        if ($urandom_range(0, 1))
        begin
            x = $signed(x) >>> 6;
            y = $signed(y) >>> 6;
        end
        for (int i = 0; i < npts; i++)
        begin
            send_point(x, y, i == npts - 1, quiet);
            if ($urandom_range(0, 2) == 0)
            begin
                x = x + 24'(int'($urandom_range(0, 2 * step)) - step);
                y = y + 24'(int'($urandom_range(0, 2 * step)) - step);
            end
        end
    endtask

    task automatic random_phase(int nlines);
        int n;
        for (int l = 0; l < nlines; l++)
        begin
            n = ($urandom_range(0, 9) == 0) ? 1 : int'($urandom_range(2, 12));
            if ($urandom_range(0, 7) == 0)
                // noise: arbitrary points across the whole range
                for (int i = 0; i < n; i++)
                    send_point(24'($urandom), 24'($urandom), i == n - 1, 1'b0);
            else
                send_line(n, int'($urandom_range(1, 600)), $urandom_range(0, 4) == 0);
        end
        drain();
    endtask

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        pt_ch.valid = 1'b0;
        pt_ch.point_x = '0;
        pt_ch.point_y = '0;
        pt_ch.end_of_line = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, negative floor, first copy, single point.
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0);
        send_point(-24'sd8388608, -24'sd8388608, 1'b1, 1'b0);
        send_point(-24'sd1, -24'sd1, 1'b0, 1'b0);
        send_point(-24'sd2, -24'sd3, 1'b0, 1'b0);
        send_point(24'sd5000, 24'sd5000, 1'b0, 1'b0);
        send_point(24'sd5001, 24'sd5002, 1'b1, 1'b0);
        send_point(24'sd0, 24'sd0, 1'b0, 1'b0);
        send_point(24'sd3000, -24'sd3000, 1'b0, 1'b0);
        send_point(24'sd3000, -24'sd3000, 1'b1, 1'b0);
        send_point(24'sd100, 24'sd100, 1'b1, 1'b0);
        send_point(-24'sd8388608, 24'sh7FFFFF, 1'b0, 1'b0);
        send_point(24'sh7FFFFF, -24'sd8388608, 1'b1, 1'b0);
        drain();

        // Sink holds off for a long stretch while points keep coming.
        hold_off = 400;
        send_line(10, 100, 1'b1);
        send_line(6, 20, 1'b1);
        drain();

        random_phase(12);

        // Tiny cells, no ends kept, zero threshold (first candidate wins).
        write_reg(hgls_pkg::CFG_KEEP_ENDS, 0);
        write_reg(hgls_pkg::CFG_COL_WIDTH, 1);
        write_reg(hgls_pkg::CFG_ROW_HEIGHT, 1);
        write_reg(hgls_pkg::CFG_INV_COL_WIDTH, 24'hFFFFFF);
        write_reg(hgls_pkg::CFG_INV_ROW_HEIGHT, 24'hFFFFFF);
        write_reg(hgls_pkg::CFG_MAX_DIST_SQ, 0);
        random_phase(5);

        // Huge cells and largest threshold: most points share a cell.
        write_reg(hgls_pkg::CFG_KEEP_ENDS, 1);
        write_reg(hgls_pkg::CFG_COL_WIDTH, 23'h7FFFFF);
        write_reg(hgls_pkg::CFG_ROW_HEIGHT, 23'h7FFFFF);
        write_reg(hgls_pkg::CFG_INV_COL_WIDTH, 1);
        write_reg(hgls_pkg::CFG_INV_ROW_HEIGHT, 1);
        write_reg(hgls_pkg::CFG_MAX_DIST_SQ, 48'hFFFFFFFFFFFF);
        random_phase(5);

        // Back to moderate cells, about four times the reset size.
        write_reg(hgls_pkg::CFG_COL_WIDTH, 1536);
        write_reg(hgls_pkg::CFG_ROW_HEIGHT, 1773);
        write_reg(hgls_pkg::CFG_INV_COL_WIDTH, 10923);
        write_reg(hgls_pkg::CFG_INV_ROW_HEIGHT, 9461);
        write_reg(hgls_pkg::CFG_MAX_DIST_SQ, 2097152);
        random_phase(4);

        stim_done = 1;
        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
